@@ rtl/ebf_pkg.sv @@
`timescale 1ns / 1ps

package ebf_pkg;

    localparam int unsigned FRAC_BITS_DEF = 8;
    localparam int unsigned STEP_W = 12;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);
    localparam int unsigned LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255);
    localparam int unsigned MODE_W = 2;
    localparam int unsigned EXP_INT_W = 6;
    localparam int unsigned FALL_START_INT = 8;
    localparam int unsigned SAT_INT = 9;
    localparam int unsigned Q_FRAC = 30;
    localparam int unsigned MANT_W = Q_FRAC + 1;
    localparam int unsigned SHIFT_W = MANT_W + 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_MIN = 2'd0,
        MODE_DEC = 2'd1,
        MODE_INC = 2'd2,
        MODE_MAX = 2'd3
    } mode_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem = x;
        res = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q30 value of 2^(f / 2^fb), built from rounded products of the roots 2^(2^-k).
    function automatic logic [MANT_W-1:0] frac_pow2(int unsigned f, int unsigned fb);
        logic [63:0] m;
        logic [63:0] root;
        m = 64'd1 << Q_FRAC;
        root = 64'd2 << Q_FRAC;
        for (int unsigned k = 1; k <= fb; k++)
        begin
            root = isqrt64(root << Q_FRAC);
            if (((f >> (fb - k)) & 1) != 0)
            begin
                m = (m * root + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
            end
        end
        return m[MANT_W-1:0];
    endfunction

endpackage

@@ rtl/ebf_if.sv @@
`timescale 1ns / 1ps

interface ebf_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [ebf_pkg::MODE_W-1:0] new_mode;

    modport source (output valid, output command, output new_mode, input ready);
    modport sink (input valid, input command, input new_mode, output ready);
endinterface

interface ebf_res_if;
    logic                        valid;
    logic                        ready;
    logic [ebf_pkg::LEVEL_W-1:0] level;
    logic [ebf_pkg::MODE_W-1:0]  mode_now;

    modport source (output valid, output level, output mode_now, input ready);
    modport sink (input valid, input level, input mode_now, output ready);
endinterface

@@ rtl/exponential_brightness_fader.sv @@
// Exponential light fader. Each request is either a tick or a mode write, and each
// produces exactly one result carrying the brightness level and the mode after it.
// In INCREASE a tick shows round(2^e - 1) for the rising exponent and then adds
// step_size to it; at full level the next tick enters MAX, which loads the falling
// exponent with 8.0, and DECREASE walks it back down to MIN. The block takes one
// request per clock cycle while the result is not stalled; a request is held in
// the input register, then the exponent table lookup, shift and rounding add run
// combinationally into the result register. step_size may only be written while
// no request is in flight.
`timescale 1ns / 1ps

module exponential_brightness_fader #(
    parameter int unsigned FRAC_BITS = ebf_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ebf_pkg::STEP_W-1:0] cfg_wdata,
    ebf_req_if.sink                    req,
    ebf_res_if.source                  res
);

    localparam int unsigned EXP_W = FRAC_BITS + ebf_pkg::EXP_INT_W;
    localparam int unsigned SUM_W = ((EXP_W > ebf_pkg::STEP_W) ? EXP_W : ebf_pkg::STEP_W) + 1;
    localparam int unsigned ROM_DEPTH = 2 ** FRAC_BITS;
    localparam logic [EXP_W-1:0] EXP_MAX = '1;
    localparam logic [EXP_W-1:0] FALL_START = EXP_W'(ebf_pkg::FALL_START_INT) << FRAC_BITS;
    localparam logic [ebf_pkg::SHIFT_W-1:0] Q_HALF =
        ebf_pkg::SHIFT_W'(1) << (ebf_pkg::Q_FRAC - 1);

    logic [ebf_pkg::MANT_W-1:0] frac_rom [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_rom
        localparam logic [ebf_pkg::MANT_W-1:0] ROM_VAL = ebf_pkg::frac_pow2(g, FRAC_BITS);
        assign frac_rom[g] = ROM_VAL;
    end

    logic [ebf_pkg::STEP_W-1:0]  step_reg;
    ebf_pkg::mode_t              mode_reg, mode_next;
    logic [ebf_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [EXP_W-1:0]            fall_reg, fall_next;
    logic [EXP_W-1:0]            rise_reg, rise_next;

    logic                        in_valid_reg, in_valid_next;
    logic                        in_cmd_reg;
    logic [ebf_pkg::MODE_W-1:0]  in_mode_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [ebf_pkg::LEVEL_W-1:0] out_level_reg;
    logic [ebf_pkg::MODE_W-1:0]  out_mode_reg;

    logic                        advance;
    logic                        process;
    logic                        req_fire;

    logic [EXP_W-1:0]                   exp_sel;
    logic [ebf_pkg::EXP_INT_W-1:0]      ipart;
    logic [ebf_pkg::MANT_W-1:0]         mant;
    logic [ebf_pkg::SHIFT_W-1:0]        shifted;
    logic [ebf_pkg::SHIFT_W-1:0]        rounded;
    logic [ebf_pkg::SHIFT_W-ebf_pkg::Q_FRAC-1:0] lev_wide;
    logic [ebf_pkg::LEVEL_W-1:0]        calc_level;

    logic [SUM_W-1:0] fall_ext, rise_ext, step_ext, fall_diff, rise_sum;

    assign advance = !out_valid_reg || res.ready;
    assign process = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign req_fire = req.valid && req.ready;

    assign res.valid = out_valid_reg;
    assign res.level = out_level_reg;
    assign res.mode_now = out_mode_reg;

    // Level for the exponent that the current mode walks.
    always_comb
    begin
        exp_sel = (mode_reg == ebf_pkg::MODE_DEC) ? fall_reg : rise_reg;
        ipart = exp_sel[EXP_W-1:FRAC_BITS];
        mant = frac_rom[exp_sel[FRAC_BITS-1:0]];
        shifted = ebf_pkg::SHIFT_W'(mant) << ipart[3:0];
        rounded = shifted - Q_HALF;
        lev_wide = rounded[ebf_pkg::SHIFT_W-1:ebf_pkg::Q_FRAC];
        if (ipart >= ebf_pkg::EXP_INT_W'(ebf_pkg::SAT_INT))
        begin
            calc_level = ebf_pkg::LEVEL_MAX;
        end
        else if (lev_wide > (ebf_pkg::SHIFT_W - ebf_pkg::Q_FRAC)'(ebf_pkg::LEVEL_MAX))
        begin
            calc_level = ebf_pkg::LEVEL_MAX;
        end
        else
        begin
            calc_level = lev_wide[ebf_pkg::LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        fall_ext = SUM_W'(fall_reg);
        rise_ext = SUM_W'(rise_reg);
        step_ext = SUM_W'(step_reg);
        fall_diff = fall_ext - step_ext;
        rise_sum = rise_ext + step_ext;

        mode_next = mode_reg;
        level_next = level_reg;
        fall_next = fall_reg;
        rise_next = rise_reg;

        if (process)
        begin
            if (in_cmd_reg == ebf_pkg::CMD_WRITE)
            begin
                mode_next = ebf_pkg::mode_t'(in_mode_reg);
            end
            else
            begin
                case (mode_reg)
                    ebf_pkg::MODE_MIN:
                    begin
                        level_next = '0;
                        rise_next = '0;
                    end
                    ebf_pkg::MODE_DEC:
                    begin
                        if (level_reg != '0)
                        begin
                            level_next = calc_level;
                            fall_next = (fall_ext > step_ext) ? EXP_W'(fall_diff) : '0;
                        end
                        else
                        begin
                            mode_next = ebf_pkg::MODE_MIN;
                        end
                    end
                    ebf_pkg::MODE_INC:
                    begin
                        if (level_reg != ebf_pkg::LEVEL_MAX)
                        begin
                            level_next = calc_level;
                            rise_next = (rise_sum > SUM_W'(EXP_MAX)) ? EXP_MAX : EXP_W'(rise_sum);
                        end
                        else
                        begin
                            mode_next = ebf_pkg::MODE_MAX;
                        end
                    end
                    ebf_pkg::MODE_MAX:
                    begin
                        level_next = ebf_pkg::LEVEL_MAX;
                        fall_next = FALL_START;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req.ready)
        begin
            in_valid_next = req.valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ebf_pkg::STEP_RESET;
            mode_reg <= ebf_pkg::MODE_MIN;
            level_reg <= '0;
            fall_reg <= '0;
            rise_reg <= '0;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            mode_reg <= mode_next;
            level_reg <= level_next;
            fall_reg <= fall_next;
            rise_reg <= rise_next;
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            in_cmd_reg <= req.command;
            in_mode_reg <= req.new_mode;
        end
        if (process)
        begin
            out_level_reg <= level_next;
            out_mode_reg <= mode_next;
        end
    end

endmodule

@@ rtl/ebf_checker.sv @@
`timescale 1ns / 1ps

module ebf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [ebf_pkg::LEVEL_W-1:0] res_level,
    input logic [ebf_pkg::MODE_W-1:0]  res_mode_now
);

    logic       req_fire;
    logic       res_fire;
    logic [2:0] pending_reg, pending_next;

    assign req_fire = req_valid && req_ready;
    assign res_fire = res_valid && res_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_fire && !res_fire)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!req_fire && res_fire)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result keeps its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_level) && $stable(res_mode_now))
        else $error("result changed while stalled");

    // Every result answers an earlier request.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> pending_reg != 3'd0)
        else $error("result without a pending request");

    // At most two requests are in flight.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("too many requests in flight");

    // With both stages full and the result stalled, no request is taken.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd2 && res_valid && !res_ready |-> !req_ready)
        else $error("request taken while full");

endmodule

bind exponential_brightness_fader ebf_checker u_ebf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_level    (res.level),
    .res_mode_now (res.mode_now)
);
